// ===== hw/rtl/mss_pkg.sv =====
// Package for the maximal square scan unit: sizes, codes and shared types.
package mss_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 11;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int IDX_W  = 2;

  // Counters hold the limit itself; indexes only the depth
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int VAL_W  = $clog2(MIN_DIM + 1);

  // Width for count compares, one bit above the widest operand
  localparam int W0    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W = ((W0 > CFG_W) ? W0 : CFG_W) + 1;

  typedef enum logic [IDX_W-1:0] {
    CFG_EMPTY    = 2'd0,
    CFG_OBSTACLE = 2'd1,
    CFG_ROWS     = 2'd2,
    CFG_COLS     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_ROW_LEN  = 2'd2,
    ST_ROW_CNT  = 2'd3
  } status_e;

  // Control carried from the accept stage into the value stage
  typedef struct packed {
    logic    valid;
    logic    lb_wr;  // a classified cell: write the line buffer
    logic    clear;  // map finished: clear scan state
    logic    res;    // a result leaves with this item
    status_e status;
    logic    empty;
    logic    first;  // first row or first column
    logic    ends;   // item closes its row
  } s1_ctrl_t;

endpackage

// ===== hw/rtl/maximal_square_scan_unit.sv =====
// Maximal square scan unit: line-buffer based largest empty square search.
//
//   chan | dir | signals                                          | transfer when
//   in   | in  | cell_char_i, row_end_i, map_end_i                | in_valid_i & in_ready_o
//   out  | out | status_o, square_size_o, square_row_o, square_col_o | out_valid_o & out_ready_i
//   cfg  | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | cfg_we_i
//
// One character per cycle while in_ready_o is high. An item is checked and counted in its
// transfer cycle while the line buffer is read; stage 1 then forms its value from the
// registered item and writes it back, and a result leaves through the output register. The
// line buffer's one read port and one write port set the rate; same-entry reads are forwarded.
// Reset clears counters and best square and restores the default registers; the line
// buffer is not cleared.
// in_ready_o drops only while a result waits behind a full, stalled output register.
module maximal_square_scan_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mss_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [mss_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mss_pkg::CHAR_W-1:0]  cell_char_i,
  input  logic                        row_end_i,
  input  logic                        map_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [mss_pkg::SIZE_W-1:0]  square_size_o,
  output logic [mss_pkg::POS_W-1:0]   square_row_o,
  output logic [mss_pkg::POS_W-1:0]   square_col_o
);

  localparam int CMP_W  = mss_pkg::CMP_W;
  localparam int VAL_W  = mss_pkg::VAL_W;
  localparam int COL_W  = mss_pkg::COL_W;
  localparam int ROW_W  = mss_pkg::ROW_W;
  localparam int COL_AW = mss_pkg::COL_AW;
  localparam int ROW_AW = mss_pkg::ROW_AW;

  // Configuration
  logic [mss_pkg::CHAR_W-1:0] empty_q, obst_q;
  logic [mss_pkg::CFG_W-1:0]  rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 8'd46;
      obst_q  <= 8'd111;
      rows_q  <= 11'd1;
      cols_q  <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mss_pkg::CFG_EMPTY:    empty_q <= cfg_wdata_i[mss_pkg::CHAR_W-1:0];
        mss_pkg::CFG_OBSTACLE: obst_q  <= cfg_wdata_i[mss_pkg::CHAR_W-1:0];
        mss_pkg::CFG_ROWS:     rows_q  <= cfg_wdata_i;
        mss_pkg::CFG_COLS:     cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 0: checks and counters at transfer time
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             err_q, err_d;
  mss_pkg::s1_ctrl_t s1_q, s1_d;
  logic [ROW_AW-1:0] s1_row_q;
  logic [COL_AW-1:0] s1_col_q;

  logic out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv     = !(s1_q.valid && s1_q.res && out_valid_q && !out_ready_i);
  assign in_ready_o = s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  logic            at_end, ends_row, is_empty, is_obst;
  logic            row_bad, col_bad, fail, ok_end;
  mss_pkg::status_e fst;
  logic [CMP_W-1:0] col_ext, row_ext, col_inc, row_inc, rows_ext, cols_ext;

  assign at_end   = map_end_i;
  assign ends_row = row_end_i | map_end_i;
  assign is_empty = (cell_char_i == empty_q);
  assign is_obst  = !is_empty && (cell_char_i == obst_q);
  assign col_ext  = CMP_W'(col_q);
  assign row_ext  = CMP_W'(row_q);
  assign col_inc  = col_ext + CMP_W'(1);
  assign row_inc  = row_ext + CMP_W'(1);
  assign rows_ext = CMP_W'(rows_q);
  assign cols_ext = CMP_W'(cols_q);
  assign row_bad  = (row_ext >= rows_ext) || (row_ext >= CMP_W'(mss_pkg::MAX_ROWS));
  assign col_bad  = (col_ext >= cols_ext) || (col_ext >= CMP_W'(mss_pkg::MAX_COLS));

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    err_d  = err_q;
    s1_d   = '0;
    fail   = 1'b0;
    ok_end = 1'b0;
    fst    = mss_pkg::ST_OK;
    if (in_acc) begin
      s1_d.valid = 1'b1;
      if (err_q) begin
        // discard until map end
        if (at_end) begin
          col_d      = '0;
          row_d      = '0;
          err_d      = 1'b0;
          s1_d.clear = 1'b1;
        end
      end else begin
        if (row_bad) begin
          fail = 1'b1;
          fst  = mss_pkg::ST_ROW_CNT;
        end else if (col_bad) begin
          fail = 1'b1;
          fst  = mss_pkg::ST_ROW_LEN;
        end else if (!(is_empty || is_obst)) begin
          fail = 1'b1;
          fst  = mss_pkg::ST_BAD_CHAR;
        end else begin
          s1_d.lb_wr = 1'b1;
          s1_d.empty = is_empty;
          s1_d.first = (row_q == '0) || (col_q == '0);
          s1_d.ends  = ends_row;
          col_d      = COL_W'(col_inc);
          if (ends_row) begin
            if (col_inc != cols_ext) begin
              fail = 1'b1;
              fst  = mss_pkg::ST_ROW_LEN;
            end else begin
              col_d = '0;
              row_d = ROW_W'(row_inc);
              if (at_end) begin
                if (row_inc != rows_ext) begin
                  fail = 1'b1;
                  fst  = mss_pkg::ST_ROW_CNT;
                end else begin
                  ok_end = 1'b1;
                end
              end
            end
          end
        end
        if (fail) begin
          s1_d.res    = 1'b1;
          s1_d.status = fst;
          if (at_end) begin
            col_d      = '0;
            row_d      = '0;
            s1_d.clear = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        if (ok_end) begin
          s1_d.res    = 1'b1;
          s1_d.status = mss_pkg::ST_OK;
          col_d       = '0;
          row_d       = '0;
          s1_d.clear  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      err_q <= 1'b0;
      s1_q  <= '0;
    end else if (s1_adv) begin
      col_q <= col_d;
      row_q <= row_d;
      err_q <= err_d;
      s1_q  <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q <= row_q[ROW_AW-1:0];
      s1_col_q <= col_q[COL_AW-1:0];
    end
  end

  // Line buffer: previous row values, one read and one write per cycle
  logic [VAL_W-1:0]  lbuf [mss_pkg::MAX_COLS];
  logic [VAL_W-1:0]  rdata_q, fwd_val_q;
  logic              fwd_q;
  logic              wr_en;
  logic [COL_AW-1:0] rd_addr;
  logic [VAL_W-1:0]  v;

  assign wr_en   = s1_q.valid && s1_q.lb_wr && s1_adv;
  assign rd_addr = col_q[COL_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lbuf[s1_col_q] <= v;
    end
    if (in_acc) begin
      rdata_q   <= lbuf[rd_addr];
      fwd_val_q <= v;
    end
  end

  // Write to the entry being read this cycle: take the new value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= wr_en && (s1_col_q == rd_addr);
    end
  end

  // Stage 1: value, best square, result
  logic [VAL_W-1:0]  left_q, diag_q, best_q, up, mn;
  logic [ROW_AW-1:0] best_row_q;
  logic [COL_AW-1:0] best_col_q;
  logic              new_best;

  assign up = fwd_q ? fwd_val_q : rdata_q;

  always_comb begin
    mn = up;
    if (left_q < mn) mn = left_q;
    if (diag_q < mn) mn = diag_q;
    if (!s1_q.empty) begin
      v = '0;
    end else if (s1_q.first) begin
      v = VAL_W'(1);
    end else begin
      v = mn + VAL_W'(1);
    end
  end

  assign new_best = s1_q.lb_wr && s1_q.empty && (v > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      diag_q     <= '0;
      best_q     <= '0;
      best_row_q <= '0;
      best_col_q <= '0;
    end else if (s1_q.valid && s1_adv) begin
      if (s1_q.clear) begin
        left_q     <= '0;
        diag_q     <= '0;
        best_q     <= '0;
        best_row_q <= '0;
        best_col_q <= '0;
      end else if (s1_q.lb_wr) begin
        left_q <= s1_q.ends ? '0 : v;
        diag_q <= s1_q.ends ? '0 : up;
        if (new_best) begin
          best_q     <= v;
          best_row_q <= s1_row_q;
          best_col_q <= s1_col_q;
        end
      end
    end
  end

  // Output register
  logic emit;
  assign emit = s1_q.valid && s1_q.res && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o <= s1_q.status;
      if (s1_q.status == mss_pkg::ST_OK) begin
        square_size_o <= mss_pkg::SIZE_W'(new_best ? v : best_q);
        square_row_o  <= mss_pkg::POS_W'(new_best ? s1_row_q : best_row_q);
        square_col_o  <= mss_pkg::POS_W'(new_best ? s1_col_q : best_col_q);
      end else begin
        square_size_o <= '0;
        square_row_o  <= '0;
        square_col_o  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions
  a_ready_only_on_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i && s1_q.valid && s1_q.res))
    else $error("input stalled without a blocked result");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result lost on its way to the output register");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_W'(mss_pkg::MAX_COLS)) && (row_q <= ROW_W'(mss_pkg::MAX_ROWS)))
    else $error("scan counter past its limit");

  a_clear_resets_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_d.clear) |=> (col_q == '0 && row_q == '0 && !err_q))
    else $error("map end did not restart the scan");

endmodule
